@@ rtl/epc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the pose-to-camera-matrix unit.
package epc_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int COEF_BITS  = 16;
	localparam int IFRAC      = 30;
	localparam int AFRAC      = ANGLE_BITS - 3;
	localparam int ASHIFT     = IFRAC - AFRAC;
	localparam int CFRAC      = COEF_BITS - 2;
	localparam int CSHIFT     = IFRAC - CFRAC;
	localparam int NCELLS     = 12;

	localparam logic signed [31:0] IONE       = 32'sh4000_0000;
	localparam logic signed [34:0] HALF_PI    = 35'sd1686629713;
	localparam logic signed [34:0] QUARTER_PI = 35'sd843314856;
	localparam logic [15:0]        SCALE_RST  = 16'd13107;

	// cell operations
	localparam logic [2:0] OP_RED  = 3'd0;
	localparam logic [2:0] OP_SQR  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_MULR = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_DIVC = 3'd5;
	localparam logic [2:0] OP_QUAD = 3'd6;

	// angle tags
	localparam logic [1:0] ID_ROLL  = 2'd0;
	localparam logic [1:0] ID_PITCH = 2'd1;
	localparam logic [1:0] ID_YAW   = 2'd2;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] roll_angle;
		logic signed [ANGLE_BITS-1:0] pitch_angle;
		logic signed [ANGLE_BITS-1:0] yaw_angle;
		logic signed [31:0]           pos_x;
		logic signed [31:0]           pos_y;
		logic signed [31:0]           pos_z;
		logic [31:0]                  fov_word;
	} cmd_t;

	typedef struct packed {
		logic [1:0]                  row_index;
		logic signed [COEF_BITS-1:0] coef_first;
		logic signed [COEF_BITS-1:0] coef_second;
		logic signed [COEF_BITS-1:0] coef_third;
		logic signed [31:0]          translation;
		logic [31:0]                 fov_out;
		logic                        last_row;
	} res_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [31:0]        fov;
	} pl_t;

	typedef struct packed {
		logic               vld;
		logic [1:0]         id;
		logic signed [2:0]  q;
		logic signed [31:0] r;
		logic signed [31:0] r2;
		logic signed [31:0] ts;
		logic signed [31:0] tc;
		pl_t                pl;
	} sc_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] ms;
		logic [5:0]  ks;
		logic [31:0] mc;
		logic [5:0]  kc;
	} cell_cfg_t;

	// Per-cell job; divide magic is ceil(2^k/d), k = 31 + ceil(log2 d), exact below 2^31.
	function automatic cell_cfg_t cell_cfg(input int idx);
		cell_cfg_t c;
		c = '{op: OP_QUAD, ms: 32'd0, ks: 6'd0, mc: 32'd0, kc: 6'd0};
		unique case (idx)
			0: c.op = OP_RED;
			1: c.op = OP_SQR;
			2: c = '{op: OP_DIV, ms: 32'd3817748708, ks: 6'd38, mc: 32'd3054198967, kc: 6'd38};
			3: c.op = OP_MUL;
			4: c = '{op: OP_DIV, ms: 32'd3272356036, ks: 6'd37, mc: 32'd2454267027, kc: 6'd37};
			5: c.op = OP_MUL;
			6: c = '{op: OP_DIV, ms: 32'd3435973837, ks: 6'd36, mc: 32'd2290649225, kc: 6'd36};
			7: c.op = OP_MUL;
			8: c = '{op: OP_DIV, ms: 32'd2863311531, ks: 6'd34, mc: 32'd2863311531, kc: 6'd35};
			9: c.op = OP_MULR;
			10: c.op = OP_DIVC;
			default: c.op = OP_QUAD;
		endcase
		return c;
	endfunction

	// Q.30 product, rounded half away from zero
	function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [30:0] ua;
		logic [30:0] ub;
		logic [61:0] p;
		logic [31:0] m;
		ua = a[31] ? 31'(-a) : a[30:0];
		ub = b[31] ? 31'(-b) : b[30:0];
		p  = 62'(ua) * 62'(ub) + (62'(1) << (IFRAC - 1));
		m  = 32'(p >> IFRAC);
		return (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
	endfunction

	// truncating divide of a non-negative value by reciprocal multiply
	function automatic logic signed [31:0] divc(input logic signed [31:0] x,
			input logic [31:0] m, input logic [5:0] k);
		logic [63:0] p;
		p = 64'(x[30:0]) * 64'(m);
		return $signed(32'(p >> k));
	endfunction

	function automatic logic signed [COEF_BITS-1:0] to_coef(input logic signed [32:0] v);
		logic [32:0] mag;
		logic [32:0] rq;
		logic [32:0] lim;
		mag = v[32] ? 33'(-v) : 33'(v);
		rq  = (mag + (33'(1) << (CSHIFT - 1))) >> CSHIFT;
		lim = 33'(1) << CFRAC;
		if (rq > lim) rq = lim;
		return v[32] ? COEF_BITS'(33'(0) - rq) : COEF_BITS'(rq);
	endfunction

endpackage

@@ rtl/epc_sc_cell.sv @@
// One sine/cosine chain cell: range reduce, square, Horner multiply or divide, quadrant fix.
module epc_sc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  epc_pkg::cell_cfg_t cfg,
	input  epc_pkg::sc_t      din,
	output epc_pkg::sc_t      dout
);

	epc_pkg::sc_t nxt;
	epc_pkg::sc_t data_q;
	logic         vld_q;

	always_comb begin
		logic signed [epc_pkg::ANGLE_BITS:0] a;
		logic signed [34:0] rw;
		logic signed [34:0] rr;
		logic signed [34:0] th;
		logic signed [2:0]  qq;
		logic signed [31:0] p;
		nxt = din;
		a   = din.r[epc_pkg::ANGLE_BITS:0];
		rw  = 35'(a) <<< epc_pkg::ASHIFT;
		rr  = rw;
		qq  = 3'sd0;
		th  = '0;
		p   = '0;
		unique case (cfg.op)
			epc_pkg::OP_RED: begin
				// fold into [-pi/4, pi/4], counting quarter turns
				for (int j = 0; j < 4; j++) begin
					th = epc_pkg::QUARTER_PI + epc_pkg::HALF_PI * 35'(j);
					if (rw > th) begin
						rr = rr - epc_pkg::HALF_PI;
						qq = qq + 3'sd1;
					end
					if (rw < -th) begin
						rr = rr + epc_pkg::HALF_PI;
						qq = qq - 3'sd1;
					end
				end
				nxt.r = 32'(rr);
				nxt.q = qq;
			end
			epc_pkg::OP_SQR: begin
				p = epc_pkg::fmul(din.r, din.r);
				nxt.r2 = p;
				nxt.ts = p;
				nxt.tc = p;
			end
			epc_pkg::OP_MUL: begin
				nxt.ts = epc_pkg::fmul(din.r2, din.ts);
				nxt.tc = epc_pkg::fmul(din.r2, din.tc);
			end
			epc_pkg::OP_MULR: begin
				nxt.ts = epc_pkg::fmul(din.r, din.ts);
				nxt.tc = epc_pkg::fmul(din.r2, din.tc);
			end
			epc_pkg::OP_DIV: begin
				nxt.ts = epc_pkg::IONE - epc_pkg::divc(din.ts, cfg.ms, cfg.ks);
				nxt.tc = epc_pkg::IONE - epc_pkg::divc(din.tc, cfg.mc, cfg.kc);
			end
			epc_pkg::OP_DIVC: begin
				nxt.tc = epc_pkg::IONE - (din.tc >>> 1);
			end
			epc_pkg::OP_QUAD: begin
				unique case (din.q[1:0])
					2'd0: ;
					2'd1: begin
						nxt.ts = din.tc;
						nxt.tc = -din.ts;
					end
					2'd2: begin
						nxt.ts = -din.ts;
						nxt.tc = -din.tc;
					end
					default: begin
						nxt.ts = -din.tc;
						nxt.tc = din.ts;
					end
				endcase
			end
			default: nxt = din;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		dout     = data_q;
		dout.vld = vld_q;
	end

endmodule

@@ rtl/epc_row_unit.sv @@
// Collects the three sin/cos pairs, builds the rotation rows and formats each result.
module epc_row_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  epc_pkg::sc_t sc,
	input  logic [15:0]  trans_scale,
	output logic         done,
	output epc_pkg::res_t result
);

	logic signed [31:0] sr_q, cr_q, sy_q, cy_q;
	logic signed [31:0] tm_q [3][3];
	logic signed [31:0] crs_q, srs_q;
	epc_pkg::pl_t       pl_q;
	logic               row_act_q;
	logic [1:0]         row_cnt_q;
	logic               yaw_in;

	logic               vld_s1;
	logic [1:0]         k_s1;
	logic signed [32:0] c0_s1, c1_s1, c2_s1;
	logic signed [31:0] pos_s1;
	logic [31:0]        fov_s1;

	logic               done_q;
	epc_pkg::res_t      res_q;

	assign yaw_in = sc.vld && (sc.id == epc_pkg::ID_YAW);

	always_ff @(posedge clk) begin
		if (sc.vld && sc.id == epc_pkg::ID_ROLL) begin
			sr_q <= sc.ts;
			cr_q <= sc.tc;
		end
		if (sc.vld && sc.id == epc_pkg::ID_PITCH) begin
			sy_q <= sc.ts;
			cy_q <= sc.tc;
		end
		// Rz*Ry, yaw arriving now
		if (yaw_in) begin
			tm_q[0][0] <= epc_pkg::fmul(sc.tc, cy_q);
			tm_q[0][1] <= sc.ts;
			tm_q[0][2] <= -epc_pkg::fmul(sc.tc, sy_q);
			tm_q[1][0] <= -epc_pkg::fmul(sc.ts, cy_q);
			tm_q[1][1] <= sc.tc;
			tm_q[1][2] <= epc_pkg::fmul(sc.ts, sy_q);
			tm_q[2][0] <= sy_q;
			tm_q[2][1] <= '0;
			tm_q[2][2] <= cy_q;
			crs_q      <= cr_q;
			srs_q      <= sr_q;
			pl_q       <= sc.pl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_act_q <= 1'b0;
			row_cnt_q <= 2'd0;
		end else if (yaw_in) begin
			row_act_q <= 1'b1;
			row_cnt_q <= 2'd0;
		end else if (row_act_q) begin
			if (row_cnt_q == 2'd2) row_act_q <= 1'b0;
			row_cnt_q <= row_cnt_q + 2'd1;
		end
	end

	// row k takes rotation row p = (1,2,0)[k], times Rx
	always_ff @(posedge clk) begin
		logic [1:0]         p;
		logic signed [32:0] v0, v1, v2;
		unique case (row_cnt_q)
			2'd0:    p = 2'd1;
			2'd1:    p = 2'd2;
			default: p = 2'd0;
		endcase
		v0 = 33'(tm_q[p][0]);
		v1 = 33'(epc_pkg::fmul(tm_q[p][1], crs_q)) - 33'(epc_pkg::fmul(tm_q[p][2], srs_q));
		v2 = 33'(epc_pkg::fmul(tm_q[p][1], srs_q)) + 33'(epc_pkg::fmul(tm_q[p][2], crs_q));
		k_s1 <= row_cnt_q;
		if (row_cnt_q == 2'd1) begin
			c0_s1 <= -v1;
			c1_s1 <= -v2;
			c2_s1 <= v0;
		end else begin
			c0_s1 <= v1;
			c1_s1 <= v2;
			c2_s1 <= -v0;
		end
		unique case (row_cnt_q)
			2'd0:    pos_s1 <= pl_q.pos_x;
			2'd1:    pos_s1 <= pl_q.pos_y;
			default: pos_s1 <= pl_q.pos_z;
		endcase
		fov_s1 <= pl_q.fov;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= row_act_q;
			done_q <= vld_s1;
		end
	end

	// scale translation, round to Q23.8, negate y and z
	always_ff @(posedge clk) begin
		logic [31:0] mag;
		logic [47:0] prod;
		logic [31:0] rnd;
		logic        neg;
		mag  = pos_s1[31] ? 32'(-pos_s1) : 32'(pos_s1);
		prod = 48'(mag) * 48'(trans_scale);
		rnd  = 32'((prod + 48'h8000) >> 16);
		neg  = pos_s1[31] ^ (k_s1 != 2'd0);
		res_q.row_index   <= k_s1;
		res_q.coef_first  <= epc_pkg::to_coef(c0_s1);
		res_q.coef_second <= epc_pkg::to_coef(c1_s1);
		res_q.coef_third  <= epc_pkg::to_coef(c2_s1);
		res_q.translation <= neg ? -$signed(rnd) : $signed(rnd);
		res_q.fov_out     <= fov_s1;
		res_q.last_row    <= (k_s1 == 2'd2);
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ rtl/euler_pose_to_camera_matrix_unit.sv @@
// Top level: pose intake, sin/cos cell chain, row builder and scale register.
//
//  channel   signals                          handshake
//  ------    -------------------------------  -----------------------------------
//  pose in   start, busy, cmd                 item taken when start && !busy
//  rows out  done, result                     one item per cycle done is high
//  config    cfg_valid, cfg_ready, cfg_data   trans_scale written on valid && ready
//
// A pose is not taken while busy; busy is high after an accept while roll and
// pitch enter the chain and drops as yaw enters; the angles enter one a cycle.
// Each angle walks a 12-cell chain (reduce, square, Horner steps, quadrant);
// the first row item shows once the yaw angle has passed the chain and the row
// unit, the next two follow in order. Rows of successive poses never overlap.
// Reset clears all valid flags and loads trans_scale with 0.2 (Q0.16).
// Results cannot be held off: each result is valid only while done is high. cfg_ready is tied high.
module euler_pose_to_camera_matrix_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  epc_pkg::cmd_t cmd,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data,
	output logic          done,
	output epc_pkg::res_t result
);

	epc_pkg::cmd_t in_q;
	logic          feed_act_q;
	logic [1:0]    feed_cnt_q;
	logic [15:0]   scale_q;
	logic          take;
	epc_pkg::sc_t  feed;
	epc_pkg::sc_t  chain [epc_pkg::NCELLS+1];

	assign cfg_ready = 1'b1;
	assign busy      = feed_act_q && (feed_cnt_q != epc_pkg::ID_YAW);
	assign take      = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= epc_pkg::SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	// angle feed sequencer: roll, pitch, yaw on consecutive cycles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_act_q <= 1'b0;
			feed_cnt_q <= epc_pkg::ID_ROLL;
		end else if (take) begin
			feed_act_q <= 1'b1;
			feed_cnt_q <= epc_pkg::ID_ROLL;
		end else if (feed_act_q) begin
			if (feed_cnt_q == epc_pkg::ID_YAW) feed_act_q <= 1'b0;
			feed_cnt_q <= feed_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) in_q <= cmd;
	end

	// pitch and yaw enter negated
	always_comb begin
		logic signed [epc_pkg::ANGLE_BITS:0] ae;
		unique case (feed_cnt_q)
			epc_pkg::ID_ROLL:  ae = (epc_pkg::ANGLE_BITS+1)'(in_q.roll_angle);
			epc_pkg::ID_PITCH: ae = -(epc_pkg::ANGLE_BITS+1)'(in_q.pitch_angle);
			default:           ae = -(epc_pkg::ANGLE_BITS+1)'(in_q.yaw_angle);
		endcase
		feed          = '0;
		feed.vld      = feed_act_q;
		feed.id       = feed_cnt_q;
		feed.r        = 32'(ae);
		feed.pl.pos_x = in_q.pos_x;
		feed.pl.pos_y = in_q.pos_y;
		feed.pl.pos_z = in_q.pos_z;
		feed.pl.fov   = in_q.fov_word;
	end

	assign chain[0] = feed;

	for (genvar g = 0; g < epc_pkg::NCELLS; g++) begin : g_cell
		epc_sc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (epc_pkg::cell_cfg(g)),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	epc_row_unit u_rows (
		.clk         (clk),
		.arst_n      (arst_n),
		.sc          (chain[epc_pkg::NCELLS]),
		.trans_scale (scale_q),
		.done        (done),
		.result      (result)
	);

endmodule

@@ test/tb_top.sv @@
// Regression bench for the pose-to-camera-matrix unit: directed and random poses with scale changes.
`timescale 1ns / 100ps

module tb_top;

	typedef longint mat3_t [3][3];

	// Q.30 working constants of the predictor
	localparam longint Q30_ONE     = 64'sd1 << 30;
	localparam longint Q30_HALF_PI = 64'sd1686629713;
	localparam longint Q30_QTR_PI  = 64'sd843314856;
	// pi/4 in angle units (Q3.13), used to aim at octant edges
	localparam int     ANG_QTR_PI  = 6434;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	epc_pkg::cmd_t cmd = '0;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	logic  [15:0] cfg_data = '0;
	logic  done;
	epc_pkg::res_t result;

	// predictor copy of the scale register
	logic  [15:0] scale_now = epc_pkg::SCALE_RST;
	// rows still owed by the unit, oldest first
	epc_pkg::res_t rows_owed[$];
	// percent of sends followed by a sender gap
	int    idle_pct = 0;
	int    n_poses = 0;
	int    n_rows = 0;
	int    n_errs = 0;
	int    n_scales = 0;

	euler_pose_to_camera_matrix_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#4000000;
		$display("euler_pose_to_camera_matrix_unit regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// round half away from zero, then shift
	function automatic longint round_shift(input longint v, input int sh);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : longint'(v);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	// Q.30 product with symmetric rounding
	function automatic longint q30_mul(input longint a, input longint b);
		longint unsigned ua;
		longint unsigned ub;
		longint unsigned p;
		ua = (a < 0) ? longint'(-a) : longint'(a);
		ub = (b < 0) ? longint'(-b) : longint'(b);
		p = (ua * ub + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	// octant reduction, Taylor series on the remainder, quadrant rotation
	function automatic void angle_sincos(input longint ang, output longint sn,
			output longint cs);
		longint r;
		longint r2;
		longint t;
		longint s;
		longint c;
		int quad;
		quad = 0;
		r = ang <<< 17;
		for (int k = 0; k < 4 && r > Q30_QTR_PI; k++) begin
			r -= Q30_HALF_PI;
			quad++;
		end
		for (int k = 0; k < 4 && r < -Q30_QTR_PI; k++) begin
			r += Q30_HALF_PI;
			quad--;
		end
		r2 = q30_mul(r, r);
		t = Q30_ONE - r2 / 72;
		t = Q30_ONE - q30_mul(r2, t) / 42;
		t = Q30_ONE - q30_mul(r2, t) / 20;
		t = Q30_ONE - q30_mul(r2, t) / 6;
		s = q30_mul(r, t);
		t = Q30_ONE - r2 / 90;
		t = Q30_ONE - q30_mul(r2, t) / 56;
		t = Q30_ONE - q30_mul(r2, t) / 30;
		t = Q30_ONE - q30_mul(r2, t) / 12;
		c = Q30_ONE - q30_mul(r2, t) / 2;
		case ((quad + 4) & 3)
			0: begin sn = s;  cs = c;  end
			1: begin sn = c;  cs = -s; end
			2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endfunction

	function automatic mat3_t mat3_mul(input mat3_t a, input mat3_t b);
		mat3_t o;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				o[i][j] = 0;
				for (int k = 0; k < 3; k++)
					o[i][j] += q30_mul(a[i][k], b[k][j]);
			end
		return o;
	endfunction

	// Q.30 to Q1.14, saturated to +-1.0
	function automatic logic [epc_pkg::COEF_BITS-1:0] q30_to_coef(input longint v);
		longint x;
		x = round_shift(v, 16);
		if (x > 16384) x = 16384;
		if (x < -16384) x = -16384;
		return x[epc_pkg::COEF_BITS-1:0];
	endfunction

	// work out the three rows of one pose and queue them
	function automatic void queue_pose_rows(input epc_pkg::cmd_t c);
		longint sr, cr, sp, cp, sy, cy;
		mat3_t mx, my, mz, rot;
		longint pos[3];
		longint e[3];
		int prm[3];
		int sgn[3];
		epc_pkg::res_t r;
		prm = '{1, 2, 0};
		sgn = '{1, -1, 1};
		angle_sincos(longint'(c.roll_angle), sr, cr);
		angle_sincos(-longint'(c.pitch_angle), sp, cp);
		angle_sincos(-longint'(c.yaw_angle), sy, cy);
		mx = '{'{Q30_ONE, 0, 0}, '{0, cr, sr}, '{0, -sr, cr}};
		my = '{'{cp, 0, -sp}, '{0, Q30_ONE, 0}, '{sp, 0, cp}};
		mz = '{'{cy, sy, 0}, '{-sy, cy, 0}, '{0, 0, Q30_ONE}};
		rot = mat3_mul(mat3_mul(mz, my), mx);
		pos[0] = longint'(c.pos_x);
		pos[1] = -longint'(c.pos_y);
		pos[2] = -longint'(c.pos_z);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				e[j] = (sgn[i] * sgn[j] < 0) ? -rot[prm[i]][prm[j]] : rot[prm[i]][prm[j]];
			r.row_index   = 2'(i);
			r.coef_first  = q30_to_coef(e[0]);
			r.coef_second = q30_to_coef(-e[1]);
			r.coef_third  = q30_to_coef(-e[2]);
			r.translation = 32'(round_shift(pos[i] * longint'(scale_now), 16));
			r.fov_out     = c.fov_word;
			r.last_row    = (i == 2);
			rows_owed.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------- checker

	function automatic void field_miss(input string name, input longint e, input longint a);
		$display("%0t: row field %s expected %0h got %0h", $time, name, e, a);
		n_errs++;
	endfunction

	// outputs settle after the edge; reading here sees the values of the cycle just ended
	always @(posedge clk) begin
		epc_pkg::res_t want;
		if (arst_n && done) begin
			n_rows++;
			if (rows_owed.size() == 0) begin
				$display("%0t: unexpected row, expected none got %h", $time, result);
				n_errs++;
			end else begin
				want = rows_owed.pop_front();
				if (result.row_index !== want.row_index)
					field_miss("row_index", want.row_index, result.row_index);
				if (result.coef_first !== want.coef_first)
					field_miss("coef_first", want.coef_first, result.coef_first);
				if (result.coef_second !== want.coef_second)
					field_miss("coef_second", want.coef_second, result.coef_second);
				if (result.coef_third !== want.coef_third)
					field_miss("coef_third", want.coef_third, result.coef_third);
				if (result.translation !== want.translation)
					field_miss("translation", want.translation, result.translation);
				if (result.fov_out !== want.fov_out)
					field_miss("fov_out", want.fov_out, result.fov_out);
				if (result.last_row !== want.last_row)
					field_miss("last_row", want.last_row, result.last_row);
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// present one pose; busy only moves on a rising edge, so the value seen
	// at the falling edge is the one the next rising edge acts on
	task automatic send_pose(input epc_pkg::cmd_t c);
		bit taken;
		start <= 1'b1;
		cmd <= c;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		queue_pose_rows(c);
		n_poses++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// let every owed row arrive, then the pipeline latency on top
	task automatic drain;
		@(posedge clk);
		start <= 1'b0;
		while (rows_owed.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	// scale write, only with the unit idle
	task automatic write_scale(input logic [15:0] v);
		bit taken;
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		scale_now = v;
		n_scales++;
	endtask

	function automatic logic [15:0] pick_angle;
		case ($urandom_range(3))
			0: return 16'($urandom);
			// near a multiple of pi/4, where the reduction changes octant
			1: return 16'($signed($urandom_range(0, 10)) * ANG_QTR_PI - 6 +
					$urandom_range(0, 12) - 5 * ANG_QTR_PI);
			2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3)) :
					16'h8000 + 16'($urandom_range(3));
			default: return 16'($signed($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	function automatic epc_pkg::cmd_t rand_pose;
		epc_pkg::cmd_t c;
		c.roll_angle  = pick_angle();
		c.pitch_angle = pick_angle();
		c.yaw_angle   = pick_angle();
		c.pos_x       = $urandom;
		c.pos_y       = $urandom;
		c.pos_z       = $urandom;
		c.fov_word    = $urandom;
		return c;
	endfunction

	// ---------------------------------------------------------------- tests

	// fixed poses: zero, field extremes, octant edges and half turns
	task automatic test_directed;
		epc_pkg::cmd_t c;
		logic [15:0] ang[10];
		ang = '{16'h0000, 16'h7fff, 16'h8000, 16'(ANG_QTR_PI), 16'(ANG_QTR_PI + 1),
			16'(-ANG_QTR_PI - 1), 16'(2 * ANG_QTR_PI), 16'(4 * ANG_QTR_PI),
			16'(-4 * ANG_QTR_PI), 16'(7 * ANG_QTR_PI + 1)};
		idle_pct = 0;
		c = '0;
		send_pose(c);
		for (int i = 1; i < 10; i++) begin
			c.roll_angle  = ang[i];
			c.pitch_angle = ang[(i + 3) % 10];
			c.yaw_angle   = ang[(i + 6) % 10];
			c.pos_x       = i[0] ? 32'h7fffffff : 32'h80000000;
			c.pos_y       = i[1] ? 32'h80000000 : 32'h7fffffff;
			c.pos_z       = i[2] ? 32'hffffffff : 32'h00000001;
			c.fov_word    = i[0] ? 32'hffffffff : 32'h00000000;
			send_pose(c);
		end
		// one axis at a time through a quarter turn
		for (int i = 0; i < 3; i++) begin
			c = '0;
			c.pos_x = 32'h00000100;
			c.pos_y = 32'hffffff00;
			c.pos_z = 32'h12345678;
			if (i == 0) c.roll_angle = 16'(2 * ANG_QTR_PI);
			if (i == 1) c.pitch_angle = 16'(2 * ANG_QTR_PI);
			if (i == 2) c.yaw_angle = 16'(-2 * ANG_QTR_PI);
			send_pose(c);
		end
	endtask

	task automatic test_random(input int n, input int pct);
		idle_pct = pct;
		for (int i = 0; i < n; i++) send_pose(rand_pose());
	endtask

	// every scale setting gets three poses, the first with extreme positions
	task automatic test_scale(input logic [15:0] v);
		epc_pkg::cmd_t c;
		write_scale(v);
		idle_pct = 50;
		for (int i = 0; i < 3; i++) begin
			c = rand_pose();
			if (i == 0) begin
				c.pos_x = 32'h80000000;
				c.pos_y = 32'h80000000;
				c.pos_z = 32'h7fffffff;
			end
			send_pose(c);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the scale is exercised first
		test_directed();
		test_random(25, 0);
		test_scale(16'hffff);
		test_random(25, 86);
		test_scale(16'h0000);
		test_scale(16'h0001);
		test_scale(16'h8000);
		test_random(25, 28);
		test_scale(16'($urandom));
		test_random(25, 0);
		test_scale(epc_pkg::SCALE_RST);

		drain();
		if (rows_owed.size() != 0) begin
			$display("%0t: %0d rows never arrived", $time, rows_owed.size());
			n_errs++;
		end
		$display("covered %0d poses, %0d rows checked, %0d scale writes, %0d mismatches",
			n_poses, n_rows, n_scales, n_errs);
		$display("angle extremes, octant edges and sender gaps of several densities");
		if (n_errs == 0) begin
			$display("euler_pose_to_camera_matrix_unit regression: pass");
		end else begin
			$display("euler_pose_to_camera_matrix_unit regression: fail");
		end
		$finish;
	end

endmodule
